[hw/rtl/sfp_pkg.sv]
// Shared types, register codes and reset values for the serial frame parser.
// No dependencies; every other RTL file refers to this package by scoped name.
`default_nettype none

package sfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LIMIT_W    = 9;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_COUNT = 6;
  localparam int unsigned GAIN_BYTE_COUNT = 12;
  localparam int unsigned GAIN_IDX_W = 4;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 9;

  // gain frames need at least this many payload bytes
  localparam logic [BYTE_W-1:0] GAIN_BYTES = 8'd12;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_LIMIT      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FRAME_TYPE = 8'd4;

  // register reset values
  localparam logic [BYTE_W-1:0]  FIRST_HEADER_RST    = 8'hAA;
  localparam logic [BYTE_W-1:0]  SECOND_HEADER_RST   = 8'hAF;
  localparam logic [LIMIT_W-1:0] TYPE_LIMIT_RST      = 9'h0F1;
  localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST    = 9'd50;
  localparam logic [BYTE_W-1:0]  GAIN_FRAME_TYPE_RST = 8'h10;

  // gain slots, in payload order
  localparam int unsigned G_ANGLE_KP = 0;
  localparam int unsigned G_ANGLE_KI = 1;
  localparam int unsigned G_ANGLE_KD = 2;
  localparam int unsigned G_RATE_KP  = 3;
  localparam int unsigned G_RATE_KI  = 4;
  localparam int unsigned G_RATE_KD  = 5;

  typedef logic signed [GAIN_W-1:0] gain_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  first_header;
    logic [BYTE_W-1:0]  second_header;
    logic [LIMIT_W-1:0] type_limit;
    logic [LIMIT_W-1:0] length_limit;
    logic [BYTE_W-1:0]  gain_frame_type;
  } cfg_t;

  // per-beat event from the framer to the gain bank
  typedef struct packed {
    logic                  wr_en;
    logic [GAIN_IDX_W-1:0] wr_idx;
    logic [BYTE_W-1:0]     wr_data;
    logic                  done;
    logic                  ok;
    logic [BYTE_W-1:0]     kind;
    logic                  load;
  } frame_evt_t;

endpackage

`default_nettype wire

[hw/rtl/sfp_rx_if.sv]
// Byte input channel: valid/ready plus one received byte.
// Depends on sfp_pkg for widths.
`default_nettype none

interface sfp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [sfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/sfp_result_if.sv]
// Result channel: frame verdict, frame type and the six held gains.
// Depends on sfp_pkg for widths and the gain type.
`default_nettype none

interface sfp_result_if;
  logic                       valid;
  logic                       ready;
  logic                       checksum_ok;
  logic [sfp_pkg::BYTE_W-1:0] frame_kind;
  logic                       gains_loaded;
  sfp_pkg::gain_t             angle_kp;
  sfp_pkg::gain_t             angle_ki;
  sfp_pkg::gain_t             angle_kd;
  sfp_pkg::gain_t             rate_kp;
  sfp_pkg::gain_t             rate_ki;
  sfp_pkg::gain_t             rate_kd;

  modport source (output valid, output checksum_ok, output frame_kind, output gains_loaded,
                  output angle_kp, output angle_ki, output angle_kd,
                  output rate_kp, output rate_ki, output rate_kd, input ready);
  modport sink   (input valid, input checksum_ok, input frame_kind, input gains_loaded,
                  input angle_kp, input angle_ki, input angle_kd,
                  input rate_kp, input rate_ki, input rate_kd, output ready);
endinterface

`default_nettype wire

[hw/rtl/sfp_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on sfp_pkg for widths.
`default_nettype none

interface sfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sfp_pkg::CFG_IDX_W-1:0]  index;
  logic [sfp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/serial_frame_parser_gain_loader_core.sv]
// Top level of the serial frame parser with gain loader.
// Depends on sfp_pkg, the three channel interfaces, sfp_cfg_regs, sfp_framer, sfp_gain_bank.
//
// Takes one received byte per beat on rx and frames it: first header, second
// header, type (below type_limit), length (below length_limit), that many
// payload bytes, then an 8-bit wrapping sum checksum over all earlier bytes.
// A byte that does not fit sends the parser back to hunting (that byte is not
// reused as a header); a zero-length frame never completes. Each checksum byte
// yields one result beat on frame with the verdict and the frame type. A good
// frame of gain_frame_type with at least 12 payload bytes loads six signed
// big-endian 16-bit gains (units of 0.001) from payload bytes 0..11; the six
// gain fields always show the gains currently held. Throughput is one byte per
// clock unless the input register stalls: it feeds the framer, whose update
// writes the result register as the checksum byte leaves the input register.
// The input register only stalls when a checksum byte meets a result beat that
// is still waiting on frame.ready. Config writes (cfg.ready is always high)
// must only happen while no result is pending.

`default_nettype none

module serial_frame_parser_gain_loader_core (
  input  wire logic    clk,
  input  wire logic    rst,
  sfp_rx_if.sink       rx,
  sfp_result_if.source frame,
  sfp_cfg_if.sink      cfg
);

  sfp_pkg::cfg_t              regs;
  sfp_pkg::frame_evt_t        evt;
  logic [sfp_pkg::PHASE_W-1:0] phase;
  logic                       out_busy;

  // input register
  logic                       s1_valid;
  logic [sfp_pkg::BYTE_W-1:0] s1_byte;
  logic                       s1_advance;

  // only a checksum byte produces a beat, so only it waits on the result register
  assign s1_advance = (phase != sfp_pkg::PH_CHECK) || !out_busy;
  assign rx.ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  sfp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sfp_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s1_valid && s1_advance),
    .rx_byte    (s1_byte),
    .regs       (regs),
    .evt        (evt),
    .phase      (phase)
  );

  sfp_gain_bank u_gains (
    .clk   (clk),
    .rst   (rst),
    .evt   (evt),
    .frame (frame),
    .busy  (out_busy)
  );

  // a gain load is only ever reported on a good frame
  a_load_needs_ok: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.gains_loaded |-> frame.checksum_ok)
    else $error("gains loaded on a frame with a bad checksum");

  // the input stage only holds back a checksum byte facing a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |-> phase == sfp_pkg::PH_CHECK && frame.valid && !frame.ready)
    else $error("input stage stalled without a pending result");

  // a new result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    evt.done |-> !out_busy)
    else $error("result beat overwritten while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !frame.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

[hw/rtl/sfp_cfg_regs.sv]
// Configuration register file for the frame parser.
// Depends on sfp_pkg and sfp_cfg_if.
`default_nettype none

module sfp_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  sfp_cfg_if.sink      cfg,
  output sfp_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_header    <= sfp_pkg::FIRST_HEADER_RST;
      regs.second_header   <= sfp_pkg::SECOND_HEADER_RST;
      regs.type_limit      <= sfp_pkg::TYPE_LIMIT_RST;
      regs.length_limit    <= sfp_pkg::LENGTH_LIMIT_RST;
      regs.gain_frame_type <= sfp_pkg::GAIN_FRAME_TYPE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sfp_pkg::REG_FIRST_HEADER:    regs.first_header    <= cfg.data[sfp_pkg::BYTE_W-1:0];
        sfp_pkg::REG_SECOND_HEADER:   regs.second_header   <= cfg.data[sfp_pkg::BYTE_W-1:0];
        sfp_pkg::REG_TYPE_LIMIT:      regs.type_limit      <= cfg.data;
        sfp_pkg::REG_LENGTH_LIMIT:    regs.length_limit    <= cfg.data;
        sfp_pkg::REG_GAIN_FRAME_TYPE: regs.gain_frame_type <= cfg.data[sfp_pkg::BYTE_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfp_framer.sv]
// Frame state machine: header/type/length checks, payload count, running sum.
// Depends on sfp_pkg; emits one frame_evt_t per processed byte.
`default_nettype none

module sfp_framer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      byte_valid,
  input  wire logic [sfp_pkg::BYTE_W-1:0] rx_byte,
  input  wire sfp_pkg::cfg_t             regs,
  output sfp_pkg::frame_evt_t            evt,
  output logic [sfp_pkg::PHASE_W-1:0]    phase
);

  logic [sfp_pkg::PHASE_W-1:0] phase_next;
  logic [sfp_pkg::BYTE_W-1:0]  bytes_left, bytes_left_next;
  logic [sfp_pkg::BYTE_W-1:0]  payload_count, payload_count_next;
  logic [sfp_pkg::BYTE_W-1:0]  running_sum, running_sum_next;
  logic [sfp_pkg::BYTE_W-1:0]  held_type, held_type_next;
  logic [sfp_pkg::BYTE_W-1:0]  sum_add;
  logic [sfp_pkg::LIMIT_W-1:0] byte_wide;

  assign sum_add   = running_sum + rx_byte;
  assign byte_wide = {1'b0, rx_byte};

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    held_type_next     = held_type;
    evt                = '0;
    evt.wr_idx         = payload_count[sfp_pkg::GAIN_IDX_W-1:0];
    evt.wr_data        = rx_byte;
    evt.kind           = held_type;
    if (byte_valid) begin
      phase_next = sfp_pkg::PH_HUNT;  // misfit byte unless a case below fits
      case (phase)
        sfp_pkg::PH_HUNT: begin
          if (rx_byte == regs.first_header) begin
            phase_next       = sfp_pkg::PH_SECOND;
            running_sum_next = rx_byte;
          end
        end
        sfp_pkg::PH_SECOND: begin
          if (rx_byte == regs.second_header) begin
            phase_next       = sfp_pkg::PH_TYPE;
            running_sum_next = sum_add;
          end
        end
        sfp_pkg::PH_TYPE: begin
          if (byte_wide < regs.type_limit) begin
            phase_next       = sfp_pkg::PH_LENGTH;
            held_type_next   = rx_byte;
            running_sum_next = sum_add;
          end
        end
        sfp_pkg::PH_LENGTH: begin
          if (byte_wide < regs.length_limit) begin
            phase_next         = sfp_pkg::PH_PAYLOAD;
            bytes_left_next    = rx_byte;
            payload_count_next = '0;
            running_sum_next   = sum_add;
          end
        end
        sfp_pkg::PH_PAYLOAD: begin
          // zero length falls through to hunting here
          if (bytes_left != '0) begin
            evt.wr_en          = (payload_count < sfp_pkg::GAIN_BYTES);
            payload_count_next = payload_count + 8'd1;
            bytes_left_next    = bytes_left - 8'd1;
            running_sum_next   = sum_add;
            phase_next = (bytes_left == 8'd1) ? sfp_pkg::PH_CHECK : sfp_pkg::PH_PAYLOAD;
          end
        end
        sfp_pkg::PH_CHECK: begin
          evt.done = 1'b1;
          evt.ok   = (running_sum == rx_byte);
          evt.load = (running_sum == rx_byte) && (held_type == regs.gain_frame_type) &&
                     (payload_count >= sfp_pkg::GAIN_BYTES);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfp_pkg::PH_HUNT;
      bytes_left    <= '0;
      payload_count <= '0;
      running_sum   <= '0;
      held_type     <= '0;
    end else begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      held_type     <= held_type_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfp_gain_bank.sv]
// Gain byte buffer, held gains and the registered result beat.
// Depends on sfp_pkg and sfp_result_if.
`default_nettype none

module sfp_gain_bank (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfp_pkg::frame_evt_t evt,
  sfp_result_if.source             frame,
  output logic                     busy
);

  logic [sfp_pkg::BYTE_W-1:0] gain_bytes [sfp_pkg::GAIN_BYTE_COUNT];
  sfp_pkg::gain_t             last_gains [sfp_pkg::GAIN_COUNT];
  logic                       valid;
  logic                       checksum_ok;
  logic [sfp_pkg::BYTE_W-1:0] frame_kind;
  logic                       gains_loaded;

  // payload buffer: no reset, only read after all twelve bytes were written
  always_ff @(posedge clk) begin
    if (evt.wr_en) begin
      gain_bytes[evt.wr_idx] <= evt.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < sfp_pkg::GAIN_COUNT; g++) begin
        last_gains[g] <= '0;
      end
    end else if (evt.load) begin
      for (int g = 0; g < sfp_pkg::GAIN_COUNT; g++) begin
        last_gains[g] <= {gain_bytes[2*g], gain_bytes[2*g+1]};  // big-endian
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (evt.done) begin
      valid <= 1'b1;
    end else if (frame.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      checksum_ok  <= evt.ok;
      frame_kind   <= evt.kind;
      gains_loaded <= evt.load;
    end
  end

  assign busy               = valid && !frame.ready;
  assign frame.valid        = valid;
  assign frame.checksum_ok  = checksum_ok;
  assign frame.frame_kind   = frame_kind;
  assign frame.gains_loaded = gains_loaded;
  // gains change only with a new beat, which waits for the previous one to drain
  assign frame.angle_kp = last_gains[sfp_pkg::G_ANGLE_KP];
  assign frame.angle_ki = last_gains[sfp_pkg::G_ANGLE_KI];
  assign frame.angle_kd = last_gains[sfp_pkg::G_ANGLE_KD];
  assign frame.rate_kp  = last_gains[sfp_pkg::G_RATE_KP];
  assign frame.rate_ki  = last_gains[sfp_pkg::G_RATE_KI];
  assign frame.rate_kd  = last_gains[sfp_pkg::G_RATE_KD];

endmodule

`default_nettype wire

[verif/tb_serial_frame_parser_gain_loader_core.sv]
// Self-checking testbench for serial_frame_parser_gain_loader_core: byte stream
// in, frame verdicts and held gains out, checked against an in-bench predictor.
// Depends on sfp_pkg and the sfp_rx_if, sfp_result_if and sfp_cfg_if interfaces.
`timescale 1ns / 1ps

module tb_serial_frame_parser_gain_loader_core;
  import sfp_pkg::*;

  // cycles with no beat on any channel before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // an index past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd5;
  // number of checked frames after which the long receiver hold-off starts
  localparam int HOLD_AFTER_FRAMES = 8;
  localparam int HOLD_CYCLES = 400;

  // one frame verdict, as seen on the result channel
  typedef struct {
    logic              ok;
    logic [BYTE_W-1:0] kind;
    logic              loaded;
    gain_t             gains[GAIN_COUNT];
  } frame_report_t;

  // receiver stall patterns
  typedef enum {DRAIN_FREE, DRAIN_HALF, DRAIN_SPARSE, DRAIN_HICCUP} drain_mode_e;

  // Tracks the framer state beat by beat and queues the verdict each
  // checksum byte should produce; result beats are checked against it.
  class gain_frame_tracker;
    cfg_t               regs;
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  bytes_left;
    logic [BYTE_W-1:0]  payload_count;
    logic [BYTE_W-1:0]  running_sum;
    logic [BYTE_W-1:0]  held_type;
    logic [BYTE_W-1:0]  gain_bytes[GAIN_BYTE_COUNT];
    gain_t              held_gains[GAIN_COUNT];
    frame_report_t      due_frames[$];
    int                 errors;
    int                 frames_checked;
    string gain_name[GAIN_COUNT] = '{"angle_kp", "angle_ki", "angle_kd",
                                     "rate_kp", "rate_ki", "rate_kd"};

    function new();
      regs = '{FIRST_HEADER_RST, SECOND_HEADER_RST, TYPE_LIMIT_RST,
               LENGTH_LIMIT_RST, GAIN_FRAME_TYPE_RST};
      phase = PH_HUNT;
      bytes_left = '0;
      payload_count = '0;
      running_sum = '0;
      held_type = '0;
      foreach (gain_bytes[i]) gain_bytes[i] = '0;
      foreach (held_gains[i]) held_gains[i] = '0;
      errors = 0;
      frames_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FIRST_HEADER:    regs.first_header    = data[BYTE_W-1:0];
        REG_SECOND_HEADER:   regs.second_header   = data[BYTE_W-1:0];
        REG_TYPE_LIMIT:      regs.type_limit      = data;
        REG_LENGTH_LIMIT:    regs.length_limit    = data;
        REG_GAIN_FRAME_TYPE: regs.gain_frame_type = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      frame_report_t report;
      logic ok, load;
      if (phase == PH_HUNT && b == regs.first_header) begin
        phase = PH_SECOND;
        running_sum = b;
      end else if (phase == PH_SECOND && b == regs.second_header) begin
        phase = PH_TYPE;
        running_sum += b;
      end else if (phase == PH_TYPE && {1'b0, b} < regs.type_limit) begin
        phase = PH_LENGTH;
        held_type = b;
        running_sum += b;
      end else if (phase == PH_LENGTH && {1'b0, b} < regs.length_limit) begin
        phase = PH_PAYLOAD;
        bytes_left = b;
        payload_count = '0;
        running_sum += b;
      end else if (phase == PH_PAYLOAD && bytes_left != 0) begin
        if (payload_count < GAIN_BYTE_COUNT) gain_bytes[payload_count] = b;
        payload_count++;
        bytes_left--;
        running_sum += b;
        if (bytes_left == 0) phase = PH_CHECK;
      end else if (phase == PH_CHECK) begin
        phase = PH_HUNT;
        ok = (running_sum == b);
        // short gain frames leave the gains alone
        load = ok && held_type == regs.gain_frame_type && payload_count >= GAIN_BYTES;
        if (load) begin
          foreach (held_gains[g]) held_gains[g] = {gain_bytes[2*g], gain_bytes[2*g+1]};
        end
        report.ok = ok;
        report.kind = held_type;
        report.loaded = load;
        report.gains = held_gains;
        due_frames.push_back(report);
      end else begin
        // misfit byte, or a zero-length frame hit by its next byte
        phase = PH_HUNT;
      end
    endfunction

    function void match_field(string field, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_frame(frame_report_t seen);
      frame_report_t want;
      frames_checked++;
      if (due_frames.size() == 0) begin
        $error("result beat with no frame pending");
        errors++;
        return;
      end
      want = due_frames.pop_front();
      match_field("checksum_ok", want.ok, seen.ok);
      match_field("frame_kind", want.kind, seen.kind);
      match_field("gains_loaded", want.loaded, seen.loaded);
      foreach (want.gains[g]) match_field(gain_name[g], want.gains[g], seen.gains[g]);
    endfunction
  endclass

  logic clk;
  logic rst;

  sfp_rx_if     rx_ch ();
  sfp_result_if result_ch ();
  sfp_cfg_if    cfg_ch ();

  serial_frame_parser_gain_loader_core uut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .frame (result_ch),
    .cfg   (cfg_ch)
  );

  gain_frame_tracker tracker = new();

  // register values as last written; used to build well-formed frames
  cfg_t live_cfg = '{FIRST_HEADER_RST, SECOND_HEADER_RST, TYPE_LIMIT_RST,
                     LENGTH_LIMIT_RST, GAIN_FRAME_TYPE_RST};
  int   burst_left = 0;
  int   bytes_sent = 0;
  int   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor: all three channels sampled at the rising edge. Result beats are
  // checked before the byte of the same edge is fed to the tracker, since a
  // result is always older than any byte taken alongside it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    frame_report_t seen;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.index, cfg_ch.data);
      if (result_ch.valid && result_ch.ready) begin
        seen.ok     = result_ch.checksum_ok;
        seen.kind   = result_ch.frame_kind;
        seen.loaded = result_ch.gains_loaded;
        seen.gains[G_ANGLE_KP] = result_ch.angle_kp;
        seen.gains[G_ANGLE_KI] = result_ch.angle_ki;
        seen.gains[G_ANGLE_KD] = result_ch.angle_kd;
        seen.gains[G_RATE_KP]  = result_ch.rate_kp;
        seen.gains[G_RATE_KI]  = result_ch.rate_ki;
        seen.gains[G_RATE_KD]  = result_ch.rate_kd;
        tracker.check_frame(seen);
      end
      if (rx_ch.valid && rx_ch.ready) tracker.take_byte(rx_ch.rx_byte);

      // watchdog: any beat on any channel counts as progress
      if ((rx_ch.valid && rx_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall patterns, plus one long hold-off once a few frames
  // are through. The sender keeps offering bytes meanwhile, so the result
  // register fills and the input backs up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    drain_mode_e mode;
    int          span;
    int          hold;
    bit          held_off;
    mode = DRAIN_FREE;
    span = 0;
    hold = 0;
    held_off = 1'b0;
    result_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && tracker.frames_checked >= HOLD_AFTER_FRAMES) begin
        held_off = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = drain_mode_e'($urandom_range(0, 3));
          span = $urandom_range(20, 80);
        end
        span--;
        case (mode)
          DRAIN_FREE:   result_ch.ready <= 1'b1;
          DRAIN_HALF:   result_ch.ready <= ($urandom_range(0, 1) == 1);
          DRAIN_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:      result_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one byte and waits for its beat. Bursts of 1..40 bytes; between
  // them a gap of idle cycles, or none at all one time in three.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  // Headers, kind, length, body and the sum byte; bad_sum flips bits of the
  // sum, a cut > 0 stops the frame after that many bytes.
  task automatic send_frame(input logic [BYTE_W-1:0] kind, input logic [BYTE_W-1:0] body[$],
                            input bit bad_sum, input int cut);
    logic [BYTE_W-1:0] beats[$];
    logic [BYTE_W-1:0] sum;
    beats = {live_cfg.first_header, live_cfg.second_header, kind, 8'(body.size())};
    beats = {beats, body};
    sum = '0;
    foreach (beats[i]) sum += beats[i];
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    beats.push_back(sum);
    if (cut <= 0 || cut > beats.size()) cut = beats.size();
    for (int i = 0; i < cut; i++) send_byte(beats[i]);
  endtask

  // Mostly well-formed frames with random content; some noise bytes, some
  // truncated frames, some bad sums. Gain frames lean toward 12..14 bytes.
  task automatic random_traffic(input int budget);
    int                stop;
    int                pick;
    int                maxl;
    int                len;
    int                cut;
    logic [BYTE_W-1:0] kind;
    logic [BYTE_W-1:0] body[$];
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(8'($urandom));
      end else if (live_cfg.type_limit == 0 || live_cfg.length_limit == 0) begin
        // no frame can form: walk the headers into a misfit
        send_byte(live_cfg.first_header);
        send_byte(live_cfg.second_header);
        send_byte(8'($urandom));
        if (pick < 50) send_byte(8'($urandom));
      end else begin
        if (live_cfg.gain_frame_type < live_cfg.type_limit && pick < 55)
          kind = live_cfg.gain_frame_type;
        else
          kind = 8'($urandom_range(0, int'(live_cfg.type_limit) - 1));
        maxl = int'(live_cfg.length_limit) - 1;
        if (maxl > 16) maxl = 16;
        if (kind == live_cfg.gain_frame_type && maxl >= 12 && $urandom_range(0, 3) != 0)
          len = $urandom_range(12, (maxl > 14) ? 14 : maxl);
        else
          len = $urandom_range(0, maxl);
        body.delete();
        repeat (len) body.push_back(8'($urandom));
        cut = ($urandom_range(0, 99) < 12) ? $urandom_range(1, len + 4) : 0;
        send_frame(kind, body, $urandom_range(0, 99) < 15, cut);
      end
    end
  endtask

  // Writes one register; apply_config writes every register, then the spare
  // index; bit 8 of the 8-bit registers is random and must be dropped.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_config(input cfg_t c);
    bit junk;
    junk = $urandom_range(0, 1);
    write_reg(REG_FIRST_HEADER, {junk, c.first_header});
    junk = $urandom_range(0, 1);
    write_reg(REG_SECOND_HEADER, {junk, c.second_header});
    write_reg(REG_TYPE_LIMIT, c.type_limit);
    write_reg(REG_LENGTH_LIMIT, c.length_limit);
    junk = $urandom_range(0, 1);
    write_reg(REG_GAIN_FRAME_TYPE, {junk, c.gain_frame_type});
    write_reg(REG_SPARE, 9'($urandom));
    cfg_ch.valid <= 1'b0;
    live_cfg = c;
  endtask

  // Drain: let the last byte land in the tracker, then wait out every pending
  // frame, then cover the two-stage pipeline.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (tracker.due_frames.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: directed corner bytes on reset registers, then random
  // traffic under several register settings, extremes included.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [BYTE_W-1:0] body[$];
    cfg_t              pick_cfg;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // repeated first header in the second slot: both bytes fall back to hunting
    send_byte(live_cfg.first_header);
    send_byte(live_cfg.first_header);
    send_byte(live_cfg.second_header);
    // type byte equal to its limit
    send_byte(live_cfg.first_header);
    send_byte(live_cfg.second_header);
    send_byte(live_cfg.type_limit[BYTE_W-1:0]);
    // length byte equal to its limit
    send_byte(live_cfg.first_header);
    send_byte(live_cfg.second_header);
    send_byte(8'h01);
    send_byte(live_cfg.length_limit[BYTE_W-1:0]);
    // zero length never completes; the header byte after it is not reused
    body.delete();
    send_frame(8'h01, body, 1'b0, 4);
    send_byte(live_cfg.first_header);
    // gain frame carrying min, max, -1, 0 and +1
    body = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
             8'h00, 8'h00, 8'h00, 8'h01, 8'h55, 8'hAA};
    send_frame(live_cfg.gain_frame_type, body, 1'b0, 0);

    random_traffic(150);
    settle();

    // low/high header extremes, widest type range, gain type at the top
    apply_config('{8'h00, 8'hFF, 9'h100, 9'd20, 8'hFF});
    random_traffic(130);
    settle();

    // zero limits: nothing may frame
    apply_config('{8'hFF, 8'h00, 9'd0, 9'd0, 8'h00});
    random_traffic(50);
    settle();

    // only kind 0 allowed, longest lengths allowed; one frame of 255 bytes
    apply_config('{8'h5A, 8'hA5, 9'd1, 9'h100, 8'h00});
    body.delete();
    repeat (255) body.push_back(8'($urandom));
    send_frame(8'h00, body, 1'b0, 0);
    random_traffic(60);
    settle();

    // random setting, gain type kept reachable
    pick_cfg.first_header    = 8'($urandom);
    pick_cfg.second_header   = 8'($urandom);
    pick_cfg.type_limit      = 9'($urandom_range(1, 256));
    pick_cfg.length_limit    = 9'($urandom_range(13, 64));
    pick_cfg.gain_frame_type = 8'($urandom_range(0, int'(pick_cfg.type_limit) - 1));
    apply_config(pick_cfg);
    random_traffic(110);
    settle();

    // back to the power-up values
    apply_config('{FIRST_HEADER_RST, SECOND_HEADER_RST, TYPE_LIMIT_RST,
                   LENGTH_LIMIT_RST, GAIN_FRAME_TYPE_RST});
    random_traffic(70);
    settle();

    if (tracker.due_frames.size() != 0)
      $error("%0d expected frames never arrived", tracker.due_frames.size());
    if (tracker.errors == 0 && tracker.due_frames.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
